// ===== src/frt_pkg.sv =====
// frt_pkg: shared types and constants for the fragment reassembly tracker
// result status codes, controller states, controller/datapath command and status structs
// no dependencies
package frt_pkg;

    localparam int unsigned MSG_W   = 32;
    localparam int unsigned IDX_W   = 16;
    localparam int unsigned TALLY_W = 16;

    localparam logic [IDX_W-1:0] END_MARK = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DUP       = 3'd1,
        ST_BAD_INDEX = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_COMPLETE  = 3'd4,
        ST_MISSING   = 3'd5
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    // one-cycle commands from the controller to the datapath
    typedef struct packed {
        logic do_frag;
        logic do_complete;
        logic scan_start;
        logic scan_step;
        logic scan_end;
    } t_dp_cmd;

    // datapath status seen by the controller
    typedef struct packed {
        logic counts_equal;
        logic scan_done;
    } t_dp_sts;

endpackage

// ===== src/frt_ctrl.sv =====
// frt_ctrl: controller state machine of the fragment reassembly tracker
// decodes accepted beats and sequences the missing-index scan
// depends on frt_pkg
module frt_ctrl import frt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_mode,
    input  t_dp_sts i_sts,
    output logic    o_busy,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_busy  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (!i_mode) begin
                        o_cmd.do_frag = 1'b1;
                    end else if (i_sts.counts_equal) begin
                        o_cmd.do_complete = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_busy = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.scan_end = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

// ===== src/frt_dp.sv =====
// frt_dp: datapath of the fragment reassembly tracker
// receive bitmap, counters, message id, scan counters and the result register
// depends on frt_pkg; driven by frt_ctrl commands
module frt_dp import frt_pkg::*; #(
    parameter int unsigned MAX_FRAGS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [MSG_W-1:0]   i_message_id,
    input  logic [IDX_W-1:0]   i_frag_index,
    input  logic [IDX_W-1:0]   i_frag_total,
    input  logic               i_checksum_ok,
    output t_dp_sts            o_sts,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [IDX_W-1:0]   o_missing_index,
    output logic [TALLY_W-1:0] o_tally,
    output logic               o_all_received,
    output logic               o_last
);

    localparam int unsigned BW = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
    localparam int unsigned CW = $clog2(MAX_FRAGS + 1);
    localparam int unsigned IW = $clog2(2 * MAX_FRAGS + 1);

    // tracker state
    logic [MAX_FRAGS-1:0] r_seen,  n_seen;
    logic [TALLY_W-1:0]   r_ec,    n_ec;
    logic [CW-1:0]        r_rc,    n_rc;
    logic [MSG_W-1:0]     r_msg,   n_msg;
    // scan counters
    logic [IW-1:0]        r_i,     n_i;
    logic [CW-1:0]        r_n,     n_n;
    // result register
    logic                 r_valid, n_valid;
    t_status              r_status, n_status;
    logic [IDX_W-1:0]     r_midx,  n_midx;
    logic [TALLY_W-1:0]   r_tally, n_tally;
    logic                 r_all,   n_all;
    logic                 r_last,  n_last;

    logic [BW-1:0]        rd_addr;
    logic                 bit_seen;
    logic                 bad_index;
    logic                 restart;
    logic                 dup;
    logic [MAX_FRAGS-1:0] seen_base;
    logic [CW-1:0]        rc_base;
    logic                 i_beyond;
    logic                 missing;

    // single bitmap read port, shared by fragment lookup and scan
    assign rd_addr  = i_cmd.scan_step ? r_i[BW-1:0] : i_frag_index[BW-1:0];
    assign bit_seen = r_seen[rd_addr];

    assign bad_index = (i_frag_index >= IDX_W'(MAX_FRAGS)) || (i_frag_index >= i_frag_total);
    assign restart   = (r_ec == '0) || (r_msg != i_message_id);
    assign dup       = !restart && bit_seen;
    assign seen_base = restart ? '0 : r_seen;
    assign rc_base   = restart ? '0 : r_rc;

    assign i_beyond = (r_i >= IW'(MAX_FRAGS));
    assign missing  = i_beyond || !bit_seen;

    assign o_sts.counts_equal = ({{(TALLY_W-CW){1'b0}}, r_rc} == r_ec);
    assign o_sts.scan_done    = ({{(TALLY_W-IW){1'b0}}, r_i} >= r_ec)
                                || (r_n == CW'(MAX_FRAGS));

    always_comb begin
        n_seen   = r_seen;
        n_ec     = r_ec;
        n_rc     = r_rc;
        n_msg    = r_msg;
        n_i      = r_i;
        n_n      = r_n;
        n_valid  = 1'b0;
        n_status = r_status;
        n_midx   = r_midx;
        n_tally  = r_tally;
        n_all    = r_all;
        n_last   = r_last;

        if (i_cmd.do_frag) begin
            n_valid = 1'b1;
            n_midx  = '0;
            n_last  = 1'b1;
            if (bad_index) begin
                n_status = ST_BAD_INDEX;
            end else if (!i_checksum_ok) begin
                n_status = ST_BAD_SUM;
            end else begin
                n_seen = seen_base;
                n_seen[i_frag_index[BW-1:0]] = 1'b1;
                if (restart) begin
                    n_msg = i_message_id;
                    n_ec  = i_frag_total;
                end
                if (dup) begin
                    n_status = ST_DUP;
                    n_rc     = rc_base;
                end else begin
                    n_status = ST_STORED;
                    n_rc     = rc_base + CW'(1);
                end
            end
            n_tally = {{(TALLY_W-CW){1'b0}}, n_rc};
            n_all   = (n_tally == n_ec);
        end

        if (i_cmd.do_complete) begin
            n_valid  = 1'b1;
            n_status = ST_COMPLETE;
            n_midx   = '0;
            n_tally  = r_ec;
            n_all    = 1'b1;
            n_last   = 1'b1;
            n_seen   = '0;
            n_ec     = '0;
            n_rc     = '0;
            n_msg    = '0;
        end

        if (i_cmd.scan_start) begin
            n_i = '0;
            n_n = '0;
        end

        if (i_cmd.scan_step) begin
            n_i = r_i + IW'(1);
            if (missing) begin
                n_valid  = 1'b1;
                n_status = ST_MISSING;
                n_midx   = {{(IDX_W-IW){1'b0}}, r_i};
                n_tally  = '0;
                n_all    = 1'b0;
                n_last   = 1'b0;
                n_n      = r_n + CW'(1);
            end
        end

        if (i_cmd.scan_end) begin
            n_valid  = 1'b1;
            n_status = ST_MISSING;
            n_midx   = END_MARK;
            n_tally  = {{(TALLY_W-CW){1'b0}}, r_n};
            n_all    = 1'b0;
            n_last   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_ec    <= '0;
            r_rc    <= '0;
            r_msg   <= '0;
            r_i     <= '0;
            r_n     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_seen  <= n_seen;
            r_ec    <= n_ec;
            r_rc    <= n_rc;
            r_msg   <= n_msg;
            r_i     <= n_i;
            r_n     <= n_n;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_midx   <= n_midx;
        r_tally  <= n_tally;
        r_all    <= n_all;
        r_last   <= n_last;
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_missing_index = r_midx;
    assign o_tally         = r_tally;
    assign o_all_received  = r_all;
    assign o_last          = r_last;

`ifndef SYNTHESIS
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rc <= CW'(MAX_FRAGS)) && (r_n <= CW'(MAX_FRAGS)))
        else $error("received or missing count above fragment limit");

    a_complete_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_COMPLETE) |-> (r_ec == '0 && r_rc == '0 && r_seen == '0))
        else $error("tracker not cleared with complete report");

    a_entry_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> (r_status == ST_MISSING && r_n != '0))
        else $error("non-final result that is not a counted missing entry");
`endif

endmodule

// ===== src/fragment_reassembly_tracker.sv =====
// fragment_reassembly_tracker: top level, receive bitmap tracker for multi-fragment messages
// joins the controller (frt_ctrl) and the datapath (frt_dp)
// depends on frt_pkg
//
// A beat is taken at a rising edge with start high and busy low. A fragment beat
// (i_mode 0) is checked, updates the bitmap and counters, and yields one result on
// the next cycle; a new fragment beat may follow in the very next cycle, so
// fragments run at one per clock. A report beat (i_mode 1) on a complete or empty
// tracker yields one complete result on the next cycle and clears the tracker, also
// at one per clock. A report on an incomplete tracker starts a scan of the bitmap,
// one index per cycle through a single bitmap read port; busy stays high until the
// scan stops at the expected count or after MAX_FRAGS missing entries. Each missing
// index comes out as its own result in the cycle after it is examined, followed by
// the end marker (index 0xFFFF, tally = missing count) with o_last set. Results are
// shown for exactly one cycle, marked by o_valid, and cannot be held off.
module fragment_reassembly_tracker import frt_pkg::*; #(
    parameter int unsigned MAX_FRAGS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command side
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [MSG_W-1:0]   i_message_id,
    input  logic [IDX_W-1:0]   i_frag_index,
    input  logic [IDX_W-1:0]   i_frag_total,
    input  logic               i_checksum_ok,
    // result side
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [IDX_W-1:0]   o_missing_index,
    output logic [TALLY_W-1:0] o_tally,
    output logic               o_all_received,
    output logic               o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // controller: beat decode and scan sequencing
    frt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // datapath: bitmap, counters and registered result
    frt_dp #(
        .MAX_FRAGS (MAX_FRAGS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_message_id    (i_message_id),
        .i_frag_index    (i_frag_index),
        .i_frag_total    (i_frag_total),
        .i_checksum_ok   (i_checksum_ok),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_missing_index (o_missing_index),
        .o_tally         (o_tally),
        .o_all_received  (o_all_received),
        .o_last          (o_last)
    );

endmodule

// ===== verif/tb_fragment_reassembly_tracker.sv =====
// tb_fragment_reassembly_tracker: self-checking testbench for the fragment reassembly tracker
// drives fragment and report beats, predicts every result and compares it field by field
// depends on frt_pkg and fragment_reassembly_tracker
module tb_fragment_reassembly_tracker;
    import frt_pkg::*;

    localparam int unsigned MAX_FRAGS  = 32;
    localparam int unsigned RANDOM_BEATS = 470;
    // watchdog limit, this leaves a wide margin over the worst case run
    localparam int unsigned TIMEOUT    = 12 * 600_000;
    localparam bit MODE_FRAG   = 1'b0;
    localparam bit MODE_REPORT = 1'b1;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_mode;
    logic [MSG_W-1:0]   i_message_id;
    logic [IDX_W-1:0]   i_frag_index;
    logic [IDX_W-1:0]   i_frag_total;
    logic               i_checksum_ok;
    logic               o_valid;
    logic [2:0]         o_status;
    logic [IDX_W-1:0]   o_missing_index;
    logic [TALLY_W-1:0] o_tally;
    logic               o_all_received;
    logic               o_last;

    fragment_reassembly_tracker #(
        .MAX_FRAGS(MAX_FRAGS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_message_id   (i_message_id),
        .i_frag_index   (i_frag_index),
        .i_frag_total   (i_frag_total),
        .i_checksum_ok  (i_checksum_ok),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_missing_index(o_missing_index),
        .o_tally        (o_tally),
        .o_all_received (o_all_received),
        .o_last         (o_last)
    );

    // one expected result beat
    typedef struct {
        t_status          status;
        logic [IDX_W-1:0] missing_index;
        logic [TALLY_W-1:0] tally;
        logic             all_received;
        logic             last;
    } t_result;

    t_result pending_results[$];

    // shadow copy of the tracker state
    bit [MAX_FRAGS-1:0] tracker_seen;
    bit [15:0]          tracker_expected;
    bit [6:0]           tracker_received;
    bit [31:0]          tracker_msg;

    int unsigned beats_sent;
    int unsigned mismatch_count;
    bit          quiet_stretch;

    // clock and reset
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    task automatic clear_tracker_model();
        tracker_seen     = '0;
        tracker_expected = '0;
        tracker_received = '0;
        tracker_msg      = '0;
    endtask

    task automatic push_result(t_status st, bit [15:0] idx, bit [15:0] tally, bit all, bit last);
        t_result r;
        r.status        = st;
        r.missing_index = idx;
        r.tally         = tally;
        r.all_received  = all;
        r.last          = last;
        pending_results.push_back(r);
    endtask

    // works out every result beat caused by one accepted beat, in order
    task automatic predict_tracker_results(bit mode, bit [31:0] msg, bit [15:0] idx,
                                           bit [15:0] total, bit ok);
        t_status     st;
        int unsigned n;
        bit          absent;
        if (mode == MODE_FRAG) begin
            // index range is checked before the checksum flag
            if (idx >= MAX_FRAGS || idx >= total) begin
                st = ST_BAD_INDEX;
            end else if (!ok) begin
                st = ST_BAD_SUM;
            end else begin
                // empty tracker or a different message restarts tracking
                if (tracker_expected == 0 || tracker_msg != msg) begin
                    clear_tracker_model();
                    tracker_msg      = msg;
                    tracker_expected = total;
                end
                if (!tracker_seen[idx[4:0]]) begin
                    tracker_seen[idx[4:0]] = 1'b1;
                    tracker_received       = tracker_received + 7'd1;
                    st = ST_STORED;
                end else begin
                    st = ST_DUP;
                end
            end
            push_result(st, '0, {9'd0, tracker_received},
                        {9'd0, tracker_received} == tracker_expected, 1'b1);
        end else if ({9'd0, tracker_received} == tracker_expected) begin
            // complete (or empty) tracker answers once and clears
            push_result(ST_COMPLETE, '0, tracker_expected, 1'b1, 1'b1);
            clear_tracker_model();
        end else begin
            // list missing indices, capped at MAX_FRAGS entries, then the end marker
            n = 0;
            for (int unsigned i = 0; i < tracker_expected && n < MAX_FRAGS; i++) begin
                absent = (i >= MAX_FRAGS) ? 1'b1 : !tracker_seen[i];
                if (absent) begin
                    push_result(ST_MISSING, 16'(i), '0, 1'b0, 1'b0);
                    n++;
                end
            end
            push_result(ST_MISSING, END_MARK, 16'(n), 1'b0, 1'b1);
        end
    endtask

    // mostly short gaps, a few long ones, none during a quiet stretch
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_stretch || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drives one beat, waits for the handshake, predicts its results, then idles a while
    task automatic send_beat(bit mode, bit [31:0] msg, bit [15:0] idx, bit [15:0] total, bit ok);
        int unsigned gap;
        start         <= 1'b1;
        i_mode        <= mode;
        i_message_id  <= msg;
        i_frag_index  <= idx;
        i_frag_total  <= total;
        i_checksum_ok <= ok;
        // beat is taken at the first edge that sees busy low
        do @(posedge i_clk); while (busy);
        predict_tracker_results(mode, msg, idx, total, ok);
        beats_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // report beat, the other fields are don't-care so they get random values
    task automatic request_report();
        send_beat(MODE_REPORT, $urandom, 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // hold the sender off until every predicted result has come out
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // report on an empty tracker, a one-fragment message, duplicate, complete report
    task automatic test_single_fragment();
        request_report();
        send_beat(MODE_FRAG, 32'h0000_0000, 16'd0, 16'd1, 1'b1);
        send_beat(MODE_FRAG, 32'h0000_0000, 16'd0, 16'd1, 1'b1);
        request_report();
        drain_results();
    endtask

    // every kind of rejection, state must stay untouched
    task automatic test_rejects();
        send_beat(MODE_FRAG, 32'h1234_5678, 16'd3, 16'd3, 1'b1);
        send_beat(MODE_FRAG, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_beat(MODE_FRAG, 32'h1234_5678, 16'd32, 16'hFFFF, 1'b1);
        send_beat(MODE_FRAG, 32'h1234_5678, 16'd31, 16'd32, 1'b0);
        // bad index wins over bad checksum
        send_beat(MODE_FRAG, 32'h1234_5678, 16'd5, 16'd0, 1'b0);
    endtask

    // partial message, repeated report, message switch, differing totals
    task automatic test_missing_list();
        send_beat(MODE_FRAG, 32'hFFFF_FFFF, 16'd1, 16'd5, 1'b1);
        send_beat(MODE_FRAG, 32'hFFFF_FFFF, 16'd3, 16'd5, 1'b1);
        request_report();
        request_report();
        // new message id clears the bitmap, expected count taken from this beat
        send_beat(MODE_FRAG, 32'h0000_0000, 16'd1, 16'd2, 1'b1);
        // same message, larger own total: index checked against it, count kept
        send_beat(MODE_FRAG, 32'h0000_0000, 16'd4, 16'd9, 1'b1);
        request_report();
        drain_results();
    endtask

    // expected count past MAX_FRAGS: unstorable indices listed, list capped
    task automatic test_list_overflow();
        send_beat(MODE_FRAG, 32'hA5A5_5A5A, 16'd0, 16'hFFFF, 1'b1);
        request_report();
        drain_results();
        // leave the tracker clean for the random part
        send_beat(MODE_FRAG, 32'h0F0F_F0F0, 16'd0, 16'd1, 1'b1);
        request_report();
    endtask

    // message sequences with random content, plus some noise beats
    task automatic test_random_traffic(int unsigned budget);
        int unsigned order[MAX_FRAGS];
        int unsigned lim;
        int unsigned k;
        int unsigned tmp;
        bit [31:0]   msg;
        bit [31:0]   prev_msg;
        bit [15:0]   total;
        bit [15:0]   this_total;
        bit          partial;
        prev_msg = $urandom;
        while (beats_sent < budget) begin
            quiet_stretch = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // noise: any field, any value
                repeat ($urandom_range(1, 4))
                    send_beat(1'($urandom), $urandom, 16'($urandom), 16'($urandom), 1'($urandom));
            end else begin
                msg = ($urandom_range(0, 3) == 0) ? prev_msg : $urandom;
                prev_msg = msg;
                case ($urandom_range(0, 9))
                    0:       total = 16'($urandom_range(MAX_FRAGS + 1, 65535));
                    1, 2:    total = 16'(MAX_FRAGS);
                    default: total = 16'($urandom_range(1, 12));
                endcase
                lim = (total > MAX_FRAGS) ? MAX_FRAGS : total;
                // shuffled arrival order
                for (int unsigned j = 0; j < lim; j++) order[j] = j;
                for (int unsigned j = lim - 1; j > 0; j--) begin
                    k        = $urandom_range(0, j);
                    tmp      = order[j];
                    order[j] = order[k];
                    order[k] = tmp;
                end
                partial = ($urandom_range(0, 2) == 0);
                for (int unsigned j = 0; j < lim; j++) begin
                    if (partial && $urandom_range(0, 3) == 0) continue;
                    this_total = ($urandom_range(0, 14) == 0) ?
                                 16'($urandom_range(order[j] + 1, 65535)) : total;
                    case ($urandom_range(0, 19))
                        0: send_beat(MODE_FRAG, msg, 16'(order[j]), this_total, 1'b0);
                        1: send_beat(MODE_FRAG, msg, 16'($urandom_range(lim, 65535)), total,
                                     1'($urandom));
                        2: request_report();
                        default: ;
                    endcase
                    send_beat(MODE_FRAG, msg, 16'(order[j]), this_total, 1'b1);
                    if (j > 0 && $urandom_range(0, 9) == 0)
                        send_beat(MODE_FRAG, msg, 16'(order[$urandom_range(0, j)]), total, 1'b1);
                end
                request_report();
                if ($urandom_range(0, 7) == 0) drain_results();
            end
        end
        quiet_stretch = 1'b0;
    endtask

    // result checker, every strobed beat is matched against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d index %0d tally %0d",
                       o_status, o_missing_index, o_tally);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_missing_index !== want.missing_index) begin
                    $error("missing_index: expected %0d, actual %0d",
                           want.missing_index, o_missing_index);
                    mismatch_count++;
                end
                if (o_tally !== want.tally) begin
                    $error("tally: expected %0d, actual %0d", want.tally, o_tally);
                    mismatch_count++;
                end
                if (o_all_received !== want.all_received) begin
                    $error("all_received: expected %0d, actual %0d",
                           want.all_received, o_all_received);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_mode        <= MODE_FRAG;
        i_message_id  <= '0;
        i_frag_index  <= '0;
        i_frag_total  <= '0;
        i_checksum_ok <= 1'b0;
        beats_sent     = 0;
        mismatch_count = 0;
        quiet_stretch  = 1'b0;
        clear_tracker_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_fragment();
        test_rejects();
        test_missing_list();
        test_list_overflow();
        test_random_traffic(beats_sent + RANDOM_BEATS);

        // let the last scan finish, then watch for stray results
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_FRAGS + 4) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT);
        $display("Test completed with failures");
        $finish;
    end

endmodule
